// ===== hw/rtl/chacha20_stream_xor_defines.svh =====
// ---------------------------------------------------------------------------
// chacha20_stream_xor_defines.svh
// Assertion macros shared by the ChaCha20 stream XOR block.
// ---------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_DEFINES_SVH
`define CHACHA20_STREAM_XOR_DEFINES_SVH

// same-cycle implication, checked on clk, held off during reset
`define CC20_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, held off during reset
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cc20_pkg.sv =====
// ---------------------------------------------------------------------------
// cc20_pkg
// Types, constants and helper functions for the ChaCha20 stream XOR block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int BLOCK_WORDS   = 16;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = $clog2(ROUNDS);
  localparam int POS_W         = $clog2(BLOCK_WORDS);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // ChaCha constant words ("expand 32-byte k")
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_NONCE_LO  = 3'd4,
    REG_NONCE_HI  = 3'd5,
    REG_INIT_CTR  = 3'd6
  } cfg_reg_t;

  // quarter-round operand roles
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  typedef logic [BLOCK_WORDS-1:0][31:0] blk_t;
  typedef logic [7:0][31:0]             key_t;
  typedef logic [2:0][31:0]             nonce_t;

  // block engine request and status
  typedef struct packed {
    logic        start;
    logic [31:0] counter;
  } blk_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } blk_sts_t;

  // state word index of one operand of a quarter round:
  // column rounds use lane k in every row, diagonal rounds shift row r by r
  function automatic logic [POS_W-1:0] qr_idx(logic diag, logic [1:0] lane,
                                               logic [1:0] role);
    logic [1:0] col;
    col = diag ? (lane + role) : lane;
    return {role, col};
  endfunction

  // 16-word input state: constants, key, block counter, nonce
  function automatic blk_t build_init(key_t key, nonce_t nonce, logic [31:0] ctr);
    blk_t s;
    for (int i = 0; i < 4; i++) begin
      s[i] = SIGMA[i];
    end
    for (int i = 0; i < 8; i++) begin
      s[4+i] = key[i];
    end
    s[12] = ctr;
    s[13] = nonce[0];
    s[14] = nonce[1];
    s[15] = nonce[2];
    return s;
  endfunction

  // valid byte count, counts above four read as four
  function automatic logic [2:0] clamp_nvalid(logic [2:0] nv);
    return (nv > 3'd4) ? 3'd4 : nv;
  endfunction

  // keep only the valid bytes
  function automatic logic [31:0] byte_mask(logic [2:0] nv);
    logic [31:0] m;
    case (nv)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/cc20_qstep.sv =====
// ---------------------------------------------------------------------------
// cc20_qstep
// One step of a ChaCha quarter round: p += q; r = rotl(r ^ p, n).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_qstep (
  input  logic [1:0]  step,
  input  logic [31:0] p,
  input  logic [31:0] q,
  input  logic [31:0] r,
  output logic [31:0] p_o,
  output logic [31:0] r_o
);

  import cc20_pkg::*;

  logic [31:0] mix;

  // add, then xor into the third operand
  assign p_o = p + q;
  assign mix = r ^ p_o;

  // rotate amount follows the step: 16, 12, 8, 7
  always_comb begin
    unique case (step)
      2'd0:    r_o = {mix[15:0], mix[31:16]};
      2'd1:    r_o = {mix[19:0], mix[31:20]};
      2'd2:    r_o = {mix[23:0], mix[31:24]};
      default: r_o = {mix[24:0], mix[31:25]};
    endcase
  end

endmodule

// ===== hw/rtl/cc20_core.sv =====
// ---------------------------------------------------------------------------
// cc20_core
// Block engine: four quarter-round step lanes driven by a round sequencer,
// then the feed-forward add. Holds the finished keystream block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cc20_pkg::key_t                 key,
  input  cc20_pkg::nonce_t               nonce,
  input  cc20_pkg::blk_req_t             req,
  input  logic [cc20_pkg::POS_W-1:0]     ks_idx,
  output logic [31:0]                    ks_word,
  output cc20_pkg::blk_sts_t             sts
);

  import cc20_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_FINAL = 3'b100
  } core_state_t;

  core_state_t      state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [31:0]      ctr_r, ctr_nxt;
  blk_t             x_r, x_nxt;
  blk_t             init_w;
  logic [31:0]      init_ctr;
  logic             diag;
  logic [3:0][31:0] p_o, r_o;

  assign diag     = rnd_r[0];
  assign init_ctr = (state_r == CS_IDLE) ? req.counter : ctr_r;
  assign init_w   = build_init(key, nonce, init_ctr);

  // four step lanes, operands picked from fixed column/diagonal taps
  for (genvar k = 0; k < 4; k++) begin : g_lane
    localparam logic [POS_W-1:0] A_C = qr_idx(1'b0, 2'(k), ROLE_A);
    localparam logic [POS_W-1:0] B_C = qr_idx(1'b0, 2'(k), ROLE_B);
    localparam logic [POS_W-1:0] C_C = qr_idx(1'b0, 2'(k), ROLE_C);
    localparam logic [POS_W-1:0] D_C = qr_idx(1'b0, 2'(k), ROLE_D);
    localparam logic [POS_W-1:0] A_D = qr_idx(1'b1, 2'(k), ROLE_A);
    localparam logic [POS_W-1:0] B_D = qr_idx(1'b1, 2'(k), ROLE_B);
    localparam logic [POS_W-1:0] C_D = qr_idx(1'b1, 2'(k), ROLE_C);
    localparam logic [POS_W-1:0] D_D = qr_idx(1'b1, 2'(k), ROLE_D);

    logic [31:0] wa, wb, wc, wd, p, q, r;

    assign wa = diag ? x_r[A_D] : x_r[A_C];
    assign wb = diag ? x_r[B_D] : x_r[B_C];
    assign wc = diag ? x_r[C_D] : x_r[C_C];
    assign wd = diag ? x_r[D_D] : x_r[D_C];

    // even steps: a += b, d mixed; odd steps: c += d, b mixed
    assign p = step_r[0] ? wc : wa;
    assign q = step_r[0] ? wd : wb;
    assign r = step_r[0] ? wb : wd;

    cc20_qstep u_qstep (
      .step (step_r),
      .p    (p),
      .q    (q),
      .r    (r),
      .p_o  (p_o[k]),
      .r_o  (r_o[k])
    );
  end

  // sequencer and working state
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    step_nxt  = step_r;
    ctr_nxt   = ctr_r;
    x_nxt     = x_r;
    unique case (state_r)
      CS_IDLE: begin
        if (req.start) begin
          x_nxt     = init_w;
          ctr_nxt   = req.counter;
          rnd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = CS_ROUND;
        end
      end
      CS_ROUND: begin
        for (int k = 0; k < 4; k++) begin
          if (step_r[0]) begin
            x_nxt[qr_idx(diag, 2'(k), ROLE_C)] = p_o[k];
            x_nxt[qr_idx(diag, 2'(k), ROLE_B)] = r_o[k];
          end else begin
            x_nxt[qr_idx(diag, 2'(k), ROLE_A)] = p_o[k];
            x_nxt[qr_idx(diag, 2'(k), ROLE_D)] = r_o[k];
          end
        end
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          rnd_nxt = rnd_r + RND_W'(1);
          if (rnd_r == RND_W'(ROUNDS - 1)) begin
            state_nxt = CS_FINAL;
          end
        end
      end
      CS_FINAL: begin
        // feed-forward add of the input state
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          x_nxt[i] = x_r[i] + init_w[i];
        end
        state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      rnd_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      step_r  <= step_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    x_r   <= x_nxt;
  end

  assign ks_word  = x_r[ks_idx];
  assign sts.busy = (state_r != CS_IDLE);
  assign sts.done = (state_r == CS_FINAL);

endmodule

// ===== hw/rtl/chacha20_stream_xor.sv =====
// ---------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 stream cipher, one 32-bit little-endian message word per handshake.
// ---------------------------------------------------------------------------
// Each accepted word is XORed with the next keystream word; bytes past
// in_valid_bytes come out as zero, and in_last ends the message so that the
// next word starts again at the initial block counter. Key, nonce and initial
// counter are written through the cfg_ port; the user must write them only
// while the block is idle, which the block itself does not enforce. For the
// first word of every 64-byte block the block engine runs 20 rounds of four
// quarter-round lanes, each lane doing one add, xor and rotate step per
// cycle, then the feed-forward add, and the word is handed over from the
// emit state. The other 15 words of the block are taken and answered one
// per cycle while the output is not stalled. A finished word waits in the
// output register while the next one is taken.
`timescale 1ns / 1ps

module chacha20_stream_xor (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // message words in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       in_data,
  input  logic [2:0]                        in_valid_bytes,
  input  logic                              in_last,
  // message words out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_data,
  output logic [2:0]                        out_valid_bytes,
  output logic                              out_last
);

  import cc20_pkg::*;

  `include "chacha20_stream_xor_defines.svh"

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_GEN  = 3'b010,
    T_EMIT = 3'b100
  } top_state_t;

  // configuration registers
  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;
  logic [31:0]      init_ctr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      init_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:     key_r[0]   <= cfg_wdata;
        REG_KEY1:     key_r[1]   <= cfg_wdata;
        REG_KEY2:     key_r[2]   <= cfg_wdata;
        REG_KEY3:     key_r[3]   <= cfg_wdata;
        REG_NONCE_LO: nonce_lo_r <= cfg_wdata;
        REG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
        REG_INIT_CTR: init_ctr_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  key_t   key_w;
  nonce_t nonce_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_w[2*i]   = key_r[i][31:0];
      key_w[2*i+1] = key_r[i][63:32];
    end
    nonce_w[0] = nonce_lo_r[31:0];
    nonce_w[1] = nonce_lo_r[63:32];
    nonce_w[2] = nonce_hi_r;
  end

  // stream position and control
  top_state_t       st_r, st_nxt;
  logic             msg_start_r, msg_start_nxt;
  logic [31:0]      ctr_r, ctr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_acc;
  logic [31:0]      ctr_eff;
  logic [POS_W-1:0] pos_eff;
  logic             need_blk;
  logic             out_free;

  // held word while a block is made or the output is busy
  logic [31:0]      hold_data_r, hold_data_nxt;
  logic [2:0]       hold_nv_r, hold_nv_nxt;
  logic             hold_last_r, hold_last_nxt;
  logic [POS_W-1:0] hold_pos_r, hold_pos_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [2:0]       out_nv_r, out_nv_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;

  blk_req_t         blk_req;
  blk_sts_t         blk_sts;
  logic [POS_W-1:0] ks_idx;
  logic [31:0]      ks_word;

  // result source: the arriving word when idle, else the held one
  logic [31:0]      res_data;
  logic [2:0]       res_nv;
  logic             res_last;

  assign in_stall = (st_r != T_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign ctr_eff  = msg_start_r ? init_ctr_r : ctr_r;
  assign pos_eff  = msg_start_r ? '0 : pos_r;
  assign need_blk = (pos_eff == '0);

  assign blk_req.start   = in_acc && need_blk;
  assign blk_req.counter = ctr_eff;
  assign ks_idx          = (st_r == T_IDLE) ? pos_eff : hold_pos_r;

  assign res_data = (st_r == T_IDLE) ? in_data : hold_data_r;
  assign res_nv   = clamp_nvalid((st_r == T_IDLE) ? in_valid_bytes : hold_nv_r);
  assign res_last = (st_r == T_IDLE) ? in_last : hold_last_r;

  cc20_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .key     (key_w),
    .nonce   (nonce_w),
    .req     (blk_req),
    .ks_idx  (ks_idx),
    .ks_word (ks_word),
    .sts     (blk_sts)
  );

  // word sequencer
  always_comb begin
    st_nxt        = st_r;
    msg_start_nxt = msg_start_r;
    ctr_nxt       = ctr_r;
    pos_nxt       = pos_r;
    hold_data_nxt = hold_data_r;
    hold_nv_nxt   = hold_nv_r;
    hold_last_nxt = hold_last_r;
    hold_pos_nxt  = hold_pos_r;
    out_load      = 1'b0;
    unique case (st_r)
      T_IDLE: begin
        if (in_acc) begin
          hold_data_nxt = in_data;
          hold_nv_nxt   = in_valid_bytes;
          hold_last_nxt = in_last;
          hold_pos_nxt  = pos_eff;
          pos_nxt       = pos_eff + POS_W'(1);
          msg_start_nxt = in_last;
          ctr_nxt       = need_blk ? (ctr_eff + 32'd1) : ctr_eff;
          if (need_blk) begin
            st_nxt = T_GEN;
          end else if (out_free) begin
            out_load = 1'b1;
          end else begin
            st_nxt = T_EMIT;
          end
        end
      end
      T_GEN: begin
        if (blk_sts.done) begin
          st_nxt = T_EMIT;
        end
      end
      T_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  // output register: loads a result, empties when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_nv_nxt    = out_nv_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (res_data ^ ks_word) & byte_mask(res_nv);
      out_nv_nxt    = res_nv;
      out_last_nxt  = res_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      msg_start_r <= 1'b1;
      ctr_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      msg_start_r <= msg_start_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_data_r <= hold_data_nxt;
    hold_nv_r   <= hold_nv_nxt;
    hold_last_r <= hold_last_nxt;
    hold_pos_r  <= hold_pos_nxt;
    out_data_r  <= out_data_nxt;
    out_nv_r    <= out_nv_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_valid_bytes = out_nv_r;
  assign out_last        = out_last_r;

  // no word taken while the block engine runs
  `CC20_ASSERT_NOW(a_no_accept_busy, blk_sts.busy, in_stall, "word accepted during block computation")
  // a new block is started only at word position zero
  `CC20_ASSERT_NOW(a_blk_at_zero, blk_req.start, pos_eff == '0, "block started mid-block")
  // a finished block is always handed to the emit stage
  `CC20_ASSERT_NEXT(a_done_emit, blk_sts.done, st_r == T_EMIT, "finished block not emitted")
  // with one valid byte, the three upper bytes are zero
  `CC20_ASSERT_NOW(a_pad_zero, out_valid && out_valid_bytes == 3'd1, out_data[31:8] == 24'd0, "invalid bytes not zero")

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ChaCha20 stream XOR block: a scoreboard
// computes the keystream for every accepted message word and compares each
// returned word field by field, over several key settings and idling modes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// one predicted or observed result word
typedef struct packed {
  logic [31:0] data;
  logic [2:0]  nbytes;
  logic        last;
} cipher_word_t;

// keystream predictor and store of expected output words
class cipher_scoreboard;
  logic [63:0]  regs [7];
  logic [31:0]  ks_block [16];
  logic [31:0]  mix [16];
  logic [31:0]  blk_ctr;
  logic [3:0]   word_pos;
  bit           msg_start;
  cipher_word_t expected_q [$];
  int unsigned  n_errors;
  int unsigned  n_words;
  int unsigned  n_msgs;
  int unsigned  n_blocks;
  int unsigned  n_writes;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (ks_block[i]) ks_block[i] = '0;
    blk_ctr   = '0;
    word_pos  = '0;
    msg_start = 1'b1;
    n_errors  = 0;
    n_words   = 0;
    n_msgs    = 0;
    n_blocks  = 0;
    n_writes  = 0;
  endfunction

  // register write; nonce_high and initial_counter keep 32 bits, index 7 is unused
  function void write_reg(logic [2:0] idx, logic [63:0] val);
    n_writes++;
    if (idx > 3'd6) return;
    if (idx >= 3'd5) val[63:32] = '0;
    regs[idx] = val;
  endfunction

  function logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void qround(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
  endfunction

  // 20 rounds over constants, key, counter and nonce, then feed-forward
  function void gen_block();
    logic [31:0] start_state [16];
    start_state[0] = 32'h61707865;
    start_state[1] = 32'h3320646e;
    start_state[2] = 32'h79622d32;
    start_state[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      start_state[4 + 2 * i] = regs[i][31:0];
      start_state[5 + 2 * i] = regs[i][63:32];
    end
    start_state[12] = blk_ctr;
    start_state[13] = regs[4][31:0];
    start_state[14] = regs[4][63:32];
    start_state[15] = regs[5][31:0];
    foreach (mix[i]) mix[i] = start_state[i];
    for (int r = 0; r < 10; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    foreach (ks_block[i]) ks_block[i] = mix[i] + start_state[i];
    n_blocks++;
  endfunction

  // accepted input word: work out the output word it should give
  function void note_word(logic [31:0] d, logic [2:0] nv, logic l);
    cipher_word_t exp;
    logic [31:0]  keep;
    logic [2:0]   n;
    if (msg_start) begin
      blk_ctr   = regs[6][31:0];
      word_pos  = '0;
      msg_start = 1'b0;
    end
    if (word_pos == 4'd0) begin
      gen_block();
      blk_ctr = blk_ctr + 32'd1;
    end
    n    = (nv > 3'd4) ? 3'd4 : nv;
    keep = (n == 3'd0) ? 32'h0 : (32'hffff_ffff >> (8 * (4 - n)));
    exp.data   = (d ^ ks_block[word_pos]) & keep;
    exp.nbytes = n;
    exp.last   = l;
    word_pos   = word_pos + 4'd1;
    if (l) begin
      msg_start = 1'b1;
      n_msgs++;
    end
    n_words++;
    expected_q.push_back(exp);
  endfunction

  function void flag(string what, logic [31:0] exp, logic [31:0] act);
    n_errors++;
    $display("%0t: %s mismatch, expected %0h got %0h", $time, what, exp, act);
  endfunction

  // returned word against the oldest prediction
  function void check_word(logic [31:0] d, logic [2:0] nv, logic l);
    cipher_word_t exp;
    if (expected_q.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected output word, expected none got %08h/%0d/%0b",
               $time, d, nv, l);
      return;
    end
    exp = expected_q.pop_front();
    if (d !== exp.data) flag("out_data", exp.data, d);
    if (nv !== exp.nbytes) flag("out_valid_bytes", exp.nbytes, nv);
    if (l !== exp.last) flag("out_last", exp.last, l);
  endfunction
endclass

module tb_top;
  import cc20_pkg::*;

  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam int         WDOG_LIMIT  = 4000;
  localparam int         SETTLE      = 200;
  localparam int         PHASE_WORDS = 195;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic [2:0]  cfg_index       = '0;
  logic [63:0] cfg_wdata       = '0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] in_data         = '0;
  logic [2:0]  in_valid_bytes  = 3'd4;
  logic        in_last         = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] out_data;
  logic [2:0]  out_valid_bytes;
  logic        out_last;

  cipher_scoreboard sb = new();
  int          send_pct = 0;
  int          recv_pct = 0;
  int          quiet_cycles = 0;
  int          n_settings = 0;

  chacha20_stream_xor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .in_valid_bytes  (in_valid_bytes),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_data, in_valid_bytes, in_last);
      if (out_valid && !out_stall) sb.check_word(out_data, out_valid_bytes, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void set_idle(idle_mode_t m);
    send_pct = (m == IDLE_SEND) ? 70 : (m == IDLE_BOTH) ? 6 : 0;
    recv_pct = (m == IDLE_RECV) ? 70 : (m == IDLE_BOTH) ? 6 : 0;
  endfunction

  // called and returns at a falling edge; leaves in_valid high
  task automatic send_word(logic [31:0] d, logic [2:0] nv, logic l);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      in_data  <= $urandom;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data        <= d;
    in_valid_bytes <= nv;
    in_last        <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly full words, a short final word, now and then an odd byte count
  task automatic send_message(int len);
    logic [31:0] d;
    logic [2:0]  nv;
    logic        l;
    for (int i = 0; i < len; i++) begin
      l  = (i == len - 1);
      nv = l ? 3'($urandom_range(1, 4)) : 3'd4;
      if ($urandom_range(99) < 8) nv = 3'($urandom_range(0, 7));
      d = $urandom;
      case ($urandom_range(15))
        0:       d = 32'h0;
        1:       d = 32'hffff_ffff;
        default: ;
      endcase
      send_word(d, nv, l);
    end
  endtask

  // wait until every word is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // key, nonce and counter for one phase
  task automatic load_setting(int p);
    logic [63:0] v [7];
    foreach (v[i]) v[i] = {$urandom, $urandom};
    case (p)
      1: foreach (v[i]) v[i] = '1;
      2: v[REG_INIT_CTR] = 64'hffff_fffe;
      3: v[REG_INIT_CTR] = '0;
      5: begin
        v[REG_KEY0] = '0; v[REG_KEY1] = '0; v[REG_KEY2] = '0; v[REG_KEY3] = '0;
        v[REG_NONCE_LO] = '0; v[REG_NONCE_HI] = '0;
      end
      default: ;
    endcase
    if (p == 3) cfg_write(REG_UNUSED, {$urandom, $urandom});
    cfg_write(REG_KEY0, v[REG_KEY0]);
    cfg_write(REG_KEY1, v[REG_KEY1]);
    cfg_write(REG_KEY2, v[REG_KEY2]);
    cfg_write(REG_KEY3, v[REG_KEY3]);
    cfg_write(REG_NONCE_LO, v[REG_NONCE_LO]);
    cfg_write(REG_NONCE_HI, v[REG_NONCE_HI]);
    cfg_write(REG_INIT_CTR, v[REG_INIT_CTR]);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  initial begin
    idle_mode_t modes [6];
    int sent;
    int len;

    modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
    set_idle(IDLE_NONE);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words on the reset key: extremes and every byte count
    send_word(32'h0, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd1, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0);
    send_word(32'hffff_ffff, 3'd3, 1'b0);
    send_word(32'hffff_ffff, 3'd5, 1'b0);
    send_word(32'hffff_ffff, 3'd6, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    send_word(32'h0, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd4, 1'b0);
    send_word(32'h5a5a_5a5a, 3'd4, 1'b0);
    send_word(32'ha5a5_a5a5, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    for (int i = 0; i < 7; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
    drain();

    // random messages, a fresh setting and idling pattern per phase
    for (int p = 1; p <= 6; p++) begin
      load_setting(p);
      set_idle(modes[p - 1]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(41, 80) : $urandom_range(1, 40);
        send_message(len);
        sent += len;
      end
      drain();
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d output words never arrived", $time, sb.expected_q.size());
      sb.n_errors++;
    end
    $display("Run covered %0d words in %0d messages, %0d keystream blocks,",
             sb.n_words, sb.n_msgs, sb.n_blocks);
    $display("%0d register writes over %0d settings and four idling patterns.",
             sb.n_writes, n_settings);
    if (sb.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_qstep.sv
hw/rtl/cc20_core.sv
hw/rtl/chacha20_stream_xor.sv
test/tb_top.sv
